// ===== hdl/sha_pkg.sv =====
// sha_pkg: shared constants, types and round functions of the sha-256 hasher
// used by sha_ctrl, sha_dpath and sha256_stream_hash
package sha_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned NUM_ROUNDS = 64;

    localparam logic [2:0] CMD_NONE = 3'd0;
    localparam logic [2:0] CMD_LOAD = 3'd1;  // pack input bytes
    localparam logic [2:0] CMD_PAD = 3'd2;   // 0x80 and zero fill
    localparam logic [2:0] CMD_LEN = 3'd3;   // zero fill and length
    localparam logic [2:0] CMD_RINIT = 3'd4; // start rounds
    localparam logic [2:0] CMD_ROUND = 3'd5;
    localparam logic [2:0] CMD_FOLD = 3'd6;  // add into chain state
    localparam logic [2:0] CMD_CLEAR = 3'd7; // back to initial state

    typedef struct packed {
        logic [2:0] op;
        logic       load_zero_only; // byte_count zero
    } t_cmd;

    typedef struct packed {
        logic       block_full;
        logic       pad_overflow;   // 0x80 landed beyond byte 55
        logic       rounds_done;
    } t_status;

    typedef logic [WORD_W-1:0] t_word;

    function automatic t_word init_hash(input logic [2:0] idx);
        t_word h;
        unique case (idx)
            3'd0: h = 32'h6a09e667;
            3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372;
            3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f;
            3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab;
            default: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

    function automatic t_word round_k(input logic [5:0] idx);
        logic [WORD_W-1:0] k [64];
        k = '{
            32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,
            32'h3956c25b,32'h59f111f1,32'h923f82a4,32'hab1c5ed5,
            32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
            32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,
            32'he49b69c1,32'hefbe4786,32'h0fc19dc6,32'h240ca1cc,
            32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
            32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,
            32'hc6e00bf3,32'hd5a79147,32'h06ca6351,32'h14292967,
            32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
            32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,
            32'ha2bfe8a1,32'ha81a664b,32'hc24b8b70,32'hc76c51a3,
            32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
            32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,
            32'h391c0cb3,32'h4ed8aa4a,32'h5b9cca4f,32'h682e6ff3,
            32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
            32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
        return k[idx];
    endfunction

    function automatic t_word rotr(input t_word x, input int unsigned n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

endpackage

// ===== hdl/sha_ctrl.sv =====
// sha_ctrl: sequencer for byte loading, padding, rounds and digest output
// depends on sha_pkg
module sha_ctrl
    import sha_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [2:0] i_in_count,
    input  logic       i_in_last,
    output logic       o_in_ready,
    input  t_status    i_status,
    output t_cmd       o_cmd,
    output logic       o_out_valid,
    output logic [2:0] o_out_index,
    input  logic       i_out_ready
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RUN = 3'd1;
    localparam logic [2:0] ST_PAD = 3'd2;
    localparam logic [2:0] ST_LEN = 3'd3;
    localparam logic [2:0] ST_OUT = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_fin, n_fin;       // message ends after current block
    logic       r_lenblk, n_lenblk; // current block carries length
    logic       r_padded, n_padded; // 0x80 already written
    logic       r_fold, n_fold;
    logic [2:0] r_idx, n_idx;
    logic       w_acc;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_acc = i_in_valid && o_in_ready;
    assign o_out_valid = (r_state == ST_OUT);
    assign o_out_index = r_idx;

    always_comb begin
        n_state = r_state;
        n_fin = r_fin;
        n_lenblk = r_lenblk;
        n_padded = r_padded;
        n_fold = 1'b0;
        n_idx = r_idx;
        o_cmd = '{op: CMD_NONE, load_zero_only: 1'b0};
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    o_cmd.op = CMD_LOAD;
                    o_cmd.load_zero_only = (i_in_count == 3'd0);
                    n_fin = i_in_last;
                    n_lenblk = 1'b0;
                    n_padded = 1'b0;
                    if (i_status.block_full)
                        n_state = ST_RUN;
                    else if (i_in_last)
                        n_state = ST_PAD;
                end
            end
            ST_PAD: begin
                o_cmd.op = CMD_PAD;
                n_padded = 1'b1;
                n_state = ST_LEN;
            end
            ST_LEN: begin
                if (i_status.pad_overflow) begin
                    n_lenblk = 1'b0;
                    n_state = ST_RUN;
                    o_cmd.op = CMD_RINIT;
                    n_fin = 1'b1;
                end else begin
                    o_cmd.op = CMD_LEN;
                    n_lenblk = 1'b1;
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (r_fold) begin
                    o_cmd.op = CMD_FOLD;
                    if (r_lenblk)
                        n_state = ST_OUT;
                    else if (r_fin && r_padded)
                        n_state = ST_LEN;
                    else if (r_fin)
                        n_state = ST_PAD;
                    else
                        n_state = ST_IDLE;
                    n_idx = 3'd0;
                end else if (i_status.rounds_done) begin
                    n_fold = 1'b1;
                end else begin
                    o_cmd.op = CMD_ROUND;
                end
            end
            ST_OUT: begin
                if (i_out_ready) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        o_cmd.op = CMD_CLEAR;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fin <= 1'b0;
            r_lenblk <= 1'b0;
            r_padded <= 1'b0;
            r_fold <= 1'b0;
            r_idx <= 3'd0;
        end else begin
            r_state <= n_state;
            r_fin <= n_fin;
            r_lenblk <= n_lenblk;
            r_padded <= n_padded;
            r_fold <= n_fold;
            r_idx <= n_idx;
        end
    end

endmodule

// ===== hdl/sha_dpath.sv =====
// sha_dpath: block buffer, message schedule, round unit and chain state
// depends on sha_pkg
module sha_dpath
    import sha_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  t_word      i_data,
    input  logic [2:0] i_count,
    input  logic [2:0] i_out_index,
    output t_status    o_status,
    output t_word      o_digest
);

    t_word       r_w [16];      // block words, then schedule window
    t_word       r_h [8];
    t_word       r_v [8];
    t_word       r_carry;       // bytes beyond a full block
    logic [5:0]  r_fill;        // bytes in block
    logic [63:0] r_len;
    logic [6:0]  r_rnd;
    logic [2:0]  w_cnt;
    logic [6:0]  w_sum;
    t_word       w_t1, w_t2, w_s0, w_s1, w_wn;

    assign w_cnt = (i_count > 3'd4) ? 3'd4 : i_count;
    assign w_sum = {1'b0, r_fill} + {4'd0, w_cnt};

    assign o_status.block_full = w_sum[6];
    assign o_status.pad_overflow = (r_fill > 6'd55);
    assign o_status.rounds_done = r_rnd[6];
    assign o_digest = r_h[i_out_index];

    assign w_s0 = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
    assign w_s1 = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
    assign w_wn = w_s1 + r_w[9] + w_s0 + r_w[0];
    assign w_t1 = r_v[7] + (rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25))
                + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
                + round_k(r_rnd[5:0]) + r_w[0];
    assign w_t2 = (rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22))
                + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    // byte write into a packed word set
    function automatic t_word put_byte(input t_word w, input logic [1:0] pos,
                                       input logic [7:0] b);
        t_word r;
        r = w;
        r[8*(3-pos) +: 8] = b;
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) r_h[i] <= init_hash(3'(i));
            r_fill <= 6'd0;
            r_len <= 64'd0;
            r_rnd <= 7'd0;
        end else begin
            unique case (i_cmd.op)
                CMD_LOAD: begin
                    // multiple bytes may share a word: write whole words
                    if (w_cnt != 3'd0) begin
                        t_word a, b2;
                        logic [5:0] p0;
                        p0 = r_fill;
                        a = r_w[p0[5:2]];
                        b2 = r_w[4'(p0[5:2] + 4'd1)];
                        for (int j = 0; j < 4; j++) begin
                            if (3'(j) < w_cnt) begin
                                logic [2:0] q;
                                q = {1'b0, p0[1:0]} + 3'(j);
                                if (!q[2]) a = put_byte(a, q[1:0], i_data[8*(3-j) +: 8]);
                                else b2 = put_byte(b2, q[1:0], i_data[8*(3-j) +: 8]);
                            end
                        end
                        r_w[p0[5:2]] <= a;
                        if ({1'b0, p0[1:0]} + w_cnt > 3'd4) begin
                            if (w_sum[6])
                                r_carry <= b2;
                            else
                                r_w[4'(p0[5:2] + 4'd1)] <= b2;
                        end
                    end
                    r_fill <= w_sum[5:0];
                    r_len <= r_len + {58'd0, w_cnt, 3'd0};
                    if (w_sum[6]) begin
                        for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                        r_rnd <= 7'd0;
                    end
                end
                CMD_PAD: begin
                    for (int k = 0; k < 16; k++) begin
                        t_word a;
                        a = r_w[k];
                        for (int m = 0; m < 4; m++) begin
                            if (6'(4*k+m) == r_fill) a[8*(3-m) +: 8] = 8'h80;
                            else if (6'(4*k+m) > r_fill) a[8*(3-m) +: 8] = 8'h00;
                        end
                        r_w[k] <= a;
                    end
                    r_rnd <= 7'd0;
                end
                CMD_RINIT: begin
                    for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                    r_rnd <= 7'd0;
                    r_fill <= 6'd0;
                end
                CMD_LEN: begin
                    // after an overflow block the buffer restarts at zero
                    if (r_fill == 6'd0 && r_rnd != 7'd0)
                        for (int k = 0; k < 14; k++) r_w[k] <= '0;
                    r_w[14] <= r_len[63:32];
                    r_w[15] <= r_len[31:0];
                    for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                    r_rnd <= 7'd0;
                end
                CMD_ROUND: begin
                    r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + w_t1;
                    r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                    r_v[0] <= w_t1 + w_t2;
                    for (int k = 0; k < 15; k++) r_w[k] <= r_w[k+1];
                    r_w[15] <= w_wn;
                    r_rnd <= r_rnd + 7'd1;
                end
                CMD_FOLD: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                    // carried bytes open the next block
                    r_w[0] <= r_carry;
                end
                CMD_CLEAR: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= init_hash(3'(i));
                    r_fill <= 6'd0;
                    r_len <= 64'd0;
                    r_rnd <= 7'd0;
                end
                default: ;
            endcase
        end
    end

endmodule

// ===== hdl/sha256_stream_hash.sv =====
// sha256_stream_hash: top level of the streaming sha-256 hasher
// depends on sha_pkg, sha_ctrl, sha_dpath
//
// input beats carry one big-endian message word, a byte count and tlast.
// a beat with tlast closes the message: padding and the length are added,
// and eight digest beats follow on the master side, index 0 first, the
// eighth with tlast. the beat that fills a 64-byte block starts 64 rounds
// in the single round unit, one round a cycle; then the end of the rounds
// is seen and a fold adds the result into the chain state, and only then
// can the slave side be ready again. after the tlast beat, padding and one
// or two compressions come before the first digest beat, and the digest
// beats go out one a cycle while the receiver is ready.
// the slave side is not ready while padding is added, a block compresses
// or a digest is pending. a stalled receiver holds the current digest beat
// and the input side stays blocked until all eight beats are taken.
// reset loads the initial hash values and empties the block.
module sha256_stream_hash
    import sha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // data_word[31:0], byte_count[34:32]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // digest_word[31:0], word_index[34:32]
    output logic        m_axis_tlast
);

    t_cmd       w_cmd;
    t_status    w_status;
    logic [2:0] w_idx;
    t_word      w_digest;

    sha_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_in_count(s_axis_tdata[34:32]),
        .i_in_last(s_axis_tlast), .o_in_ready(s_axis_tready),
        .i_status(w_status), .o_cmd(w_cmd),
        .o_out_valid(m_axis_tvalid), .o_out_index(w_idx),
        .i_out_ready(m_axis_tready)
    );

    sha_dpath u_dpath (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd),
        .i_data(s_axis_tdata[31:0]), .i_count(s_axis_tdata[34:32]),
        .i_out_index(w_idx), .o_status(w_status), .o_digest(w_digest)
    );

    assign m_axis_tdata = {5'd0, w_idx, w_digest};
    assign m_axis_tlast = (w_idx == 3'd7);

endmodule

// ===== dv/sha256_stream_checker.sv =====
// sha256_stream_checker: watches both streams of sha256_stream_hash, predicts
// digests with its own sha-256 message model and compares every digest beat
`timescale 1ns / 100ps

module sha256_stream_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [39:0] i_in_data,
    input  logic        i_in_last,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [39:0] i_out_data,
    input  logic        i_out_last,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_digest_beat;

    logic [31:0]  chain [8];
    logic [7:0]   blk [64];
    int unsigned  fill;
    logic [63:0]  msg_bits;
    t_digest_beat digest_q [$];

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] kconst(input int i);
        logic [31:0] k [64];
        k = '{
            32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,
            32'h3956c25b,32'h59f111f1,32'h923f82a4,32'hab1c5ed5,
            32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
            32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,
            32'he49b69c1,32'hefbe4786,32'h0fc19dc6,32'h240ca1cc,
            32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
            32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,
            32'hc6e00bf3,32'hd5a79147,32'h06ca6351,32'h14292967,
            32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
            32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,
            32'ha2bfe8a1,32'ha81a664b,32'hc24b8b70,32'hc76c51a3,
            32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
            32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,
            32'h391c0cb3,32'h4ed8aa4a,32'h5b9cca4f,32'h682e6ff3,
            32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
            32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
        return k[i];
    endfunction

    task automatic start_message();
        chain = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                  32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
        fill = 0;
        msg_bits = '0;
    endtask

    task automatic compress();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2, s0, s1;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        for (int i = 16; i < 64; i++) begin
            s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = s1 + w[i-7] + s0 + w[i-16];
        end
        v = chain;
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + kconst(i) + w[i];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            chain[i] = chain[i] + v[i];
    endtask

    task automatic absorb_word(input logic [31:0] word, input logic [2:0] cnt,
                               input logic is_last);
        int unsigned n;
        t_digest_beat b;
        n = (cnt > 4) ? 4 : cnt;
        for (int i = 0; i < n; i++) begin
            blk[fill] = word[31-8*i -: 8];
            fill++;
            msg_bits += 8;
            if (fill == 64) begin
                compress();
                fill = 0;
            end
        end
        if (is_last) begin
            blk[fill] = 8'h80;
            fill++;
            if (fill > 56) begin
                for (int i = fill; i < 64; i++) blk[i] = 8'h00;
                compress();
                fill = 0;
            end
            for (int i = fill; i < 56; i++) blk[i] = 8'h00;
            for (int i = 0; i < 8; i++) blk[56+i] = msg_bits[63-8*i -: 8];
            compress();
            for (int i = 0; i < 8; i++) begin
                b.digest_word = chain[i];
                b.word_index = i[2:0];
                b.last_word = (i == 7);
                digest_q.push_back(b);
            end
            start_message();
        end
    endtask

    always @(posedge i_clk) begin
        t_digest_beat got, want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
            o_pending <= 0;
            digest_q.delete();
            start_message();
        end else begin
            if (i_in_valid && i_in_ready)
                absorb_word(i_in_data[31:0], i_in_data[34:32], i_in_last);
            if (i_out_valid && i_out_ready) begin
                got.digest_word = i_out_data[31:0];
                got.word_index = i_out_data[34:32];
                got.last_word = i_out_last;
                if (digest_q.size() == 0) begin
                    $display("%0t: unexpected digest beat expected none actual %h",
                             $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = digest_q.pop_front();
                    if (got != want) begin
                        $display("%0t: digest mismatch expected %h/%0d/%0b actual %h/%0d/%0b",
                                 $time, want.digest_word, want.word_index, want.last_word,
                                 got.digest_word, got.word_index, got.last_word);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_pending <= digest_q.size();
        end
    end

endmodule

// ===== dv/tb_sha256_stream_hash.sv =====
// tb_sha256_stream_hash: stimulus and verdict for sha256_stream_hash
// drives message words under several source idle and receiver stall mixes; sha256_stream_checker judges
`timescale 1ns / 100ps

module tb_sha256_stream_hash;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // data_word[31:0], byte_count[34:32]
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // digest_word[31:0], word_index[34:32]
    logic        m_axis_tlast;
    int          fail_count;
    int          pending;
    int          src_idle_pct = 0;
    int          dst_stall_pct = 0;
    longint      cycles = 0;

    always #6 i_clk = ~i_clk;

    sha256_stream_hash u_top (.*);

    sha256_stream_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready),
        .i_in_data(s_axis_tdata), .i_in_last(s_axis_tlast),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata), .i_out_last(m_axis_tlast),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("tb_sha256_stream_hash NOT OK");
            $finish;
        end
    end

    always @(negedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= dst_stall_pct);

    task automatic send_word(input logic [31:0] word, input logic [2:0] cnt,
                             input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'd0, cnt, word};
        s_axis_tlast <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_message(input int n_words, input int short_pct);
        logic [2:0] c;
        for (int i = 0; i < n_words; i++) begin
            c = ($urandom_range(99) < short_pct) ? 3'($urandom_range(7)) : 3'd4;
            if (c == 0 && i != n_words - 1) c = 3'd4;
            send_word($urandom, c, i == n_words - 1);
        end
    endtask

    initial begin
        int n;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        // empty message, then zero-count words that are ignored
        send_word(32'hffffffff, 3'd0, 1'b1);
        send_word(32'hffffffff, 3'd0, 1'b0);
        send_word(32'h61626300, 3'd3, 1'b1);
        send_word(32'h00000000, 3'd7, 1'b0);
        send_word(32'hffffffff, 3'd5, 1'b1);
        // 55 and 56 bytes: padding fits, or needs an extra block
        for (int i = 0; i < 14; i++)
            send_word(32'ha5a5a5a5 ^ i, i == 13 ? 3'd3 : 3'd4, i == 13);
        for (int i = 0; i < 14; i++)
            send_word(32'h5a5a5a5a ^ i, 3'd4, i == 13);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        for (int ph = 0; ph < 4; ph++) begin
            src_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 81 : 34) : 0;
            dst_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 81 : 34) : 0;
            for (int cnt_words = 0; cnt_words < 70; cnt_words += n) begin
                n = ($urandom_range(9) == 0) ? $urandom_range(17, 40)
                                              : $urandom_range(1, 17);
                send_message(n, 30);
            end
        end
        s_axis_tvalid <= 1'b0;
        src_idle_pct = 0;
        dst_stall_pct = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
        if (fail_count == 0)
            $display("tb_sha256_stream_hash OK");
        else
            $display("tb_sha256_stream_hash NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/sha_pkg.sv
hdl/sha_ctrl.sv
hdl/sha_dpath.sv
hdl/sha256_stream_hash.sv
dv/sha256_stream_checker.sv
dv/tb_sha256_stream_hash.sv
